FILE: src/playfair_digraph_cipher_macros.svh
// Assertion helpers shared by the cipher RTL. Each use sits on a line of its own.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PFC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define PFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and small helper functions for the Playfair block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHA       = 26;
    localparam int CODE_W      = $clog2(ALPHA);
    localparam int CELL_W      = $clog2(CELLS);
    localparam int FILL_W      = $clog2(CELLS + 1);
    localparam int RC_W        = $clog2(SQUARE_SIDE);
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [RC_W-1:0]   t_rc;

    localparam t_code CODE_V     = t_code'(21);
    localparam t_code CODE_W_LTR = t_code'(22);
    localparam t_code CODE_X     = t_code'(23);
    localparam t_cell ABSENT_POS = t_cell'(31);

    localparam logic [7:0] ASCII_UC_A  = 8'd65;
    localparam logic [7:0] ASCII_UC_Z  = 8'd90;
    localparam logic [7:0] ASCII_LC_A  = 8'd97;
    localparam logic [7:0] ASCII_LC_Z  = 8'd122;
    localparam logic [7:0] ASCII_SPACE = 8'd32;
    localparam logic [6:0] LETTER_BASE = 7'd65;

    typedef enum logic [2:0] {
        K_KEY_CHAR,
        K_KEY_END,
        K_TEXT_CHAR,
        K_TEXT_END,
        K_PAIR,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_PAIR,
        ST_BAD_CHAR,
        ST_KEY_BAD
    } t_status;

    typedef struct packed {
        t_kind kind;
        t_code code_a;
        t_code code_b;
        logic  a_letter;
        logic  a_space;
        logic  pair_ok;
    } t_op;

    typedef struct packed {
        logic  ok;
        t_code code;
    } t_letter;

    // Letter code 0..25 for either case.
    function automatic t_letter letter_decode(input logic [7:0] c);
        t_letter    res;
        logic [7:0] d;
        res = '0;
        d   = '0;
        if (c >= ASCII_UC_A && c <= ASCII_UC_Z) begin
            d      = c - ASCII_UC_A;
            res.ok = 1'b1;
        end else if (c >= ASCII_LC_A && c <= ASCII_LC_Z) begin
            d      = c - ASCII_LC_A;
            res.ok = 1'b1;
        end
        res.code = d[CODE_W-1:0];
        return res;
    endfunction

    function automatic t_rc cell_row(input t_cell p);
        t_rc r;
        r = '0;
        for (int k = 1; k < SQUARE_SIDE; k++) begin
            if (p >= t_cell'(k * SQUARE_SIDE)) r = t_rc'(k);
        end
        return r;
    endfunction

    function automatic t_rc cell_col(input t_cell p);
        t_cell t;
        t = p - t_cell'(cell_row(p)) * t_cell'(SQUARE_SIDE);
        return t[RC_W-1:0];
    endfunction

    function automatic t_cell cell_index(input t_rc r, input t_rc c);
        return t_cell'(r) * t_cell'(SQUARE_SIDE) + t_cell'(c);
    endfunction

    // One place along a row or column, wrapping; backward when decrypting.
    function automatic t_rc rc_step(input t_rc v, input logic dec);
        t_rc r;
        if (dec) r = (v == '0) ? t_rc'(SQUARE_SIDE - 1) : v - t_rc'(1);
        else     r = (v == t_rc'(SQUARE_SIDE - 1)) ? '0 : v + t_rc'(1);
        return r;
    endfunction

    function automatic t_cell cell_wrap(input t_cell p);
        return (p >= t_cell'(CELLS)) ? p - t_cell'(CELLS) : p;
    endfunction

endpackage

`default_nettype wire

FILE: src/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Decodes the command and classifies the two input bytes of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front (
    input  logic [2:0]   i_cmd,
    input  logic [7:0]   i_char_first,
    input  logic [7:0]   i_char_second,
    output pfc_pkg::t_op o_op
);
    import pfc_pkg::*;

    localparam logic [2:0] CMD_KEY_CHAR  = 3'd0;
    localparam logic [2:0] CMD_KEY_END   = 3'd1;
    localparam logic [2:0] CMD_TEXT_CHAR = 3'd2;
    localparam logic [2:0] CMD_TEXT_END  = 3'd3;
    localparam logic [2:0] CMD_PAIR      = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    t_letter la;
    t_letter lb;
    t_kind   kind;

    always_comb begin
        la = letter_decode(i_char_first);
        lb = letter_decode(i_char_second);
        unique case (i_cmd)
            CMD_KEY_CHAR:  kind = K_KEY_CHAR;
            CMD_KEY_END:   kind = K_KEY_END;
            CMD_TEXT_CHAR: kind = K_TEXT_CHAR;
            CMD_TEXT_END:  kind = K_TEXT_END;
            CMD_PAIR:      kind = K_PAIR;
            CMD_CLEAR:     kind = K_CLEAR;
            default:       kind = K_NOP;
        endcase

        o_op.kind     = kind;
        o_op.a_letter = la.ok;
        o_op.a_space  = (i_char_first == ASCII_SPACE);
        // Key and plaintext read W as V; a ciphertext W is rejected instead.
        o_op.code_a   = (la.code == CODE_W_LTR && kind != K_PAIR) ? CODE_V : la.code;
        o_op.code_b   = lb.code;
        o_op.pair_ok  = la.ok && lb.ok && la.code != CODE_W_LTR && lb.code != CODE_W_LTR;
    end

endmodule

`default_nettype wire

FILE: src/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Short FIFO of decoded words between the front end and the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  pfc_pkg::t_op i_op,
    output logic         o_ready,
    output logic         o_valid,
    output pfc_pkg::t_op o_op,
    input  logic         i_pop
);
    import pfc_pkg::*;
    `include "playfair_digraph_cipher_macros.svh"

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    t_op  r_mem [QUEUE_DEPTH];
    t_idx r_wr;
    t_idx r_rd;
    t_cnt r_count;
    logic push_acc;
    logic pop_acc;

    assign o_ready  = (r_count != t_cnt'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_op     = r_mem[r_rd];
    assign push_acc = i_push && o_ready;
    assign pop_acc  = i_pop && o_valid;

    function automatic t_idx idx_next(input t_idx v);
        return (v == t_idx'(QUEUE_DEPTH - 1)) ? '0 : v + t_idx'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_acc) r_wr <= idx_next(r_wr);
            if (pop_acc)  r_rd <= idx_next(r_rd);
            if (push_acc && !pop_acc)      r_count <= r_count + t_cnt'(1);
            else if (pop_acc && !push_acc) r_count <= r_count - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_acc) r_mem[r_wr] <= i_op;
    end

    `PFC_ASSERT_ALWAYS(a_q_count_bound, i_clk, i_rst_n, r_count <= t_cnt'(QUEUE_DEPTH), "queue count above depth")
    `PFC_ASSERT_NEXT(a_q_count_up, i_clk, i_rst_n, push_acc && !pop_acc, r_count == $past(r_count) + t_cnt'(1), "queue count missed a push")
    `PFC_ASSERT_NEXT(a_q_count_dn, i_clk, i_rst_n, pop_acc && !push_acc, r_count == $past(r_count) - t_cnt'(1), "queue count missed a pop")

endmodule

`default_nettype wire

FILE: src/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Execution unit: builds the key square, holds the pending plaintext letter
// and runs the digraph lookups through the position and square memories.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  pfc_pkg::t_op i_op,
    output logic         o_op_pop,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [1:0]   o_status,
    output logic [6:0]   o_letter_first,
    output logic [6:0]   o_letter_second
);
    import pfc_pkg::*;
    `include "playfair_digraph_cipher_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_FILL_DONE,
        S_POS,
        S_SQR
    } t_state;

    t_state  r_state, n_state;
    logic [ALPHA-1:0] r_pos_valid, n_pos_valid;
    t_fill   r_key_fill, n_key_fill;
    logic    r_key_ready, n_key_ready;
    logic    r_key_invalid, n_key_invalid;
    t_code   r_pend, n_pend;
    logic    r_pend_valid, n_pend_valid;
    t_code   r_fill_idx, n_fill_idx;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic [6:0] r_out_first, n_out_first;
    logic [6:0] r_out_second, n_out_second;

    // Memories and their read registers.
    t_code r_sq_mem  [CELLS];
    t_cell r_pos_mem [ALPHA];
    t_cell r_pos_a, r_pos_b;
    logic  r_pva, r_pvb;
    logic  r_dec;
    t_code r_sq_a, r_sq_b;

    logic  out_free;
    logic  place_req;
    t_code place_code;
    logic  place_we;
    logic  pos_re;
    t_code pos_ra_a, pos_ra_b;
    logic  dec_sel;
    logic  sq_re;
    t_cell sq_ra_a, sq_ra_b;

    t_cell pa, pb;
    t_rc   ra, ca, rb, cb;

    assign out_free = !r_out_valid || i_out_ready;

    // Cell coordinates of the two letters, from the registered positions.
    always_comb begin
        pa = cell_wrap(r_pva ? r_pos_a : ABSENT_POS);
        pb = cell_wrap(r_pvb ? r_pos_b : ABSENT_POS);
        ra = cell_row(pa);
        ca = cell_col(pa);
        rb = cell_row(pb);
        cb = cell_col(pb);
    end

    always_comb begin
        n_state       = r_state;
        n_pos_valid   = r_pos_valid;
        n_key_fill    = r_key_fill;
        n_key_ready   = r_key_ready;
        n_key_invalid = r_key_invalid;
        n_pend        = r_pend;
        n_pend_valid  = r_pend_valid;
        n_fill_idx    = r_fill_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_first   = r_out_first;
        n_out_second  = r_out_second;
        o_op_pop      = 1'b0;
        place_req     = 1'b0;
        place_code    = i_op.code_a;
        place_we      = 1'b0;
        pos_re        = 1'b0;
        pos_ra_a      = i_op.code_a;
        pos_ra_b      = i_op.code_b;
        dec_sel       = 1'b0;
        sq_re         = 1'b0;
        sq_ra_a       = cell_index(ra, cb);
        sq_ra_b       = cell_index(rb, ca);

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid && out_free) begin
                    o_op_pop     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NONE;
                    n_out_first  = '0;
                    n_out_second = '0;
                    if (i_op.kind == K_CLEAR) begin
                        n_pos_valid   = '0;
                        n_key_fill    = '0;
                        n_key_ready   = 1'b0;
                        n_key_invalid = 1'b0;
                        n_pend        = '0;
                        n_pend_valid  = 1'b0;
                    end else if (i_op.kind == K_NOP) begin
                        n_out_status = ST_NONE;
                    end else if (r_key_invalid) begin
                        n_out_status = ST_KEY_BAD;
                    end else if (i_op.kind == K_KEY_CHAR) begin
                        if (!r_key_ready) begin
                            if (i_op.a_letter) begin
                                place_req = 1'b1;
                            end else if (!i_op.a_space || r_key_fill == '0) begin
                                n_key_invalid = 1'b1;
                                n_out_status  = ST_KEY_BAD;
                            end
                        end
                    end else if (i_op.kind == K_KEY_END) begin
                        if (!r_key_ready) begin
                            n_out_valid = 1'b0;
                            n_fill_idx  = '0;
                            n_state     = S_FILL;
                        end
                    end else if (!r_key_ready) begin
                        n_out_status = ST_KEY_BAD;
                    end else begin
                        case (i_op.kind)
                            K_TEXT_CHAR: begin
                                if (i_op.a_space) begin
                                    n_out_status = ST_NONE;
                                end else if (!i_op.a_letter) begin
                                    n_out_status = ST_BAD_CHAR;
                                end else if (!r_pend_valid) begin
                                    n_pend       = i_op.code_a;
                                    n_pend_valid = 1'b1;
                                end else begin
                                    n_out_valid = 1'b0;
                                    pos_re      = 1'b1;
                                    pos_ra_a    = r_pend;
                                    n_state     = S_POS;
                                    // A doubled letter other than X pairs with X and stays pending.
                                    if (r_pend == i_op.code_a && i_op.code_a != CODE_X) begin
                                        pos_ra_b = CODE_X;
                                    end else begin
                                        pos_ra_b     = i_op.code_a;
                                        n_pend       = '0;
                                        n_pend_valid = 1'b0;
                                    end
                                end
                            end
                            K_TEXT_END: begin
                                if (r_pend_valid) begin
                                    n_out_valid  = 1'b0;
                                    pos_re       = 1'b1;
                                    pos_ra_a     = r_pend;
                                    pos_ra_b     = CODE_X;
                                    n_pend       = '0;
                                    n_pend_valid = 1'b0;
                                    n_state      = S_POS;
                                end
                            end
                            K_PAIR: begin
                                if (!i_op.pair_ok) begin
                                    n_out_status = ST_BAD_CHAR;
                                end else begin
                                    n_out_valid = 1'b0;
                                    pos_re      = 1'b1;
                                    dec_sel     = 1'b1;
                                    n_state     = S_POS;
                                end
                            end
                            default: begin
                                n_out_status = ST_NONE;
                            end
                        endcase
                    end
                end
            end
            S_FILL: begin
                place_code = r_fill_idx;
                place_req  = (r_fill_idx != CODE_W_LTR);
                if (r_fill_idx == t_code'(ALPHA - 1)) begin
                    n_key_ready = 1'b1;
                    n_state     = S_FILL_DONE;
                end else begin
                    n_fill_idx = r_fill_idx + t_code'(1);
                end
            end
            S_FILL_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NONE;
                    n_out_first  = '0;
                    n_out_second = '0;
                    n_state      = S_IDLE;
                end
            end
            S_POS: begin
                sq_re = 1'b1;
                if (ca == cb) begin
                    sq_ra_a = cell_index(rc_step(ra, r_dec), ca);
                    sq_ra_b = cell_index(rc_step(rb, r_dec), cb);
                end else if (ra == rb) begin
                    sq_ra_a = cell_index(ra, rc_step(ca, r_dec));
                    sq_ra_b = cell_index(rb, rc_step(cb, r_dec));
                end
                n_state = S_SQR;
            end
            S_SQR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_PAIR;
                    n_out_first  = LETTER_BASE + 7'(r_sq_a);
                    n_out_second = LETTER_BASE + 7'(r_sq_b);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Key placement: a letter already in the square is skipped.
        if (place_req && !r_pos_valid[place_code] && r_key_fill < t_fill'(CELLS)) begin
            place_we                = 1'b1;
            n_pos_valid[place_code] = 1'b1;
            n_key_fill              = r_key_fill + t_fill'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pos_valid   <= '0;
            r_key_fill    <= '0;
            r_key_ready   <= 1'b0;
            r_key_invalid <= 1'b0;
            r_pend        <= '0;
            r_pend_valid  <= 1'b0;
            r_fill_idx    <= '0;
            r_out_valid   <= 1'b0;
            r_out_status  <= ST_NONE;
            r_out_first   <= '0;
            r_out_second  <= '0;
        end else begin
            r_state       <= n_state;
            r_pos_valid   <= n_pos_valid;
            r_key_fill    <= n_key_fill;
            r_key_ready   <= n_key_ready;
            r_key_invalid <= n_key_invalid;
            r_pend        <= n_pend;
            r_pend_valid  <= n_pend_valid;
            r_fill_idx    <= n_fill_idx;
            r_out_valid   <= n_out_valid;
            r_out_status  <= n_out_status;
            r_out_first   <= n_out_first;
            r_out_second  <= n_out_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_we) begin
            r_sq_mem[r_key_fill[CELL_W-1:0]] <= place_code;
            r_pos_mem[place_code]            <= r_key_fill[CELL_W-1:0];
        end
        if (pos_re) begin
            r_pos_a <= r_pos_mem[pos_ra_a];
            r_pos_b <= r_pos_mem[pos_ra_b];
            r_pva   <= r_pos_valid[pos_ra_a];
            r_pvb   <= r_pos_valid[pos_ra_b];
            r_dec   <= dec_sel;
        end
        if (sq_re) begin
            r_sq_a <= r_sq_mem[sq_ra_a];
            r_sq_b <= r_sq_mem[sq_ra_b];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_letter_first  = r_out_first;
    assign o_letter_second = r_out_second;

    `PFC_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_key_fill <= t_fill'(CELLS), "key fill count above square size")
    `PFC_ASSERT_IMPLY(a_pair_needs_key, i_clk, i_rst_n, r_out_valid && r_out_status == ST_PAIR, r_key_ready && !r_key_invalid, "pair result without a finished key")
    `PFC_ASSERT_NEXT(a_fill_complete, i_clk, i_rst_n, r_state == S_FILL && r_fill_idx == t_code'(ALPHA - 1), r_key_fill == t_fill'(CELLS) && r_key_ready, "square not full after key fill")

endmodule

`default_nettype wire

FILE: src/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a 5x5 square without W, with key loading,
// plaintext digraph encryption and ciphertext pair decryption.
// ----------------------------------------------------------------------------
// Each input word passes through a decoder into a two-word queue and is then
// executed one at a time. Once at the head of the queue, key characters,
// rejected characters and other words that make no pair finish when taken;
// a digraph passes through a position memory read, a square memory read and
// the result register; end of key takes the word, lets the fill walk all 26
// letters once, and then loads the result register.
// A result that waits to be taken holds the next word at the head of the
// queue, and the queue keeps accepting words until it holds two. No clearing
// pass runs after reset: letter presence is kept in flip-flops that reset and
// the clear-key command empty at once.
`default_nettype none

module playfair_digraph_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_char_first,
    input  logic [7:0] i_char_second,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [6:0] o_letter_first,
    output logic [6:0] o_letter_second
);
    import pfc_pkg::*;

    t_op  dec_op;
    t_op  q_op;
    logic q_valid;
    logic q_pop;

    pfc_front u_front (
        .i_cmd         (i_cmd),
        .i_char_first  (i_char_first),
        .i_char_second (i_char_second),
        .o_op          (dec_op)
    );

    pfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_op    (dec_op),
        .o_ready (o_in_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    pfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (q_valid),
        .i_op            (q_op),
        .o_op_pop        (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_letter_first  (o_letter_first),
        .o_letter_second (o_letter_second)
    );

endmodule

`default_nettype wire
